>>> src/mmps_pkg.sv
`default_nettype none

package mmps_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BODY = 1'b1;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_DASH = 8'h2D;

	typedef enum logic [1:0] {
		KIND_BYTE     = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_ABANDON  = 2'd2,
		KIND_END      = 2'd3
	} kind_t;

	typedef struct packed {
		logic       op;
		logic [6:0] char_index;
		logic [7:0] data_byte;
		logic       end_of_body;
	} in_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] part_byte;
		logic       last_of_run;
	} out_item_t;

	// All results caused by one body byte, in release order.
	typedef struct packed {
		logic       byte_v;
		logic [7:0] part_byte;
		logic       comp_v;
		logic       ab_v;
		logic       end_v;
	} bundle_t;

endpackage

`default_nettype wire

>>> src/mmps_cell.sv
`default_nettype none

module mmps_cell
	import mmps_pkg::*;
#(
	parameter logic [7:0] INIT_BYTE = 8'h00
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       ld,
	input  wire logic [7:0] byte_in,
	input  wire logic       ins,
	input  wire logic [7:0] dly_in,
	output logic            hit,
	output logic [7:0]      dly_out
);

	logic [7:0] pat_q;
	logic [7:0] dly_q;
	logic [7:0] dly_nx;

	// Byte this window position holds once the current byte is shifted in
	assign dly_nx  = ins ? byte_in : dly_in;
	assign hit     = (dly_nx == pat_q);
	assign dly_out = dly_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= INIT_BYTE;
		end else if (ld) begin
			pat_q <= byte_in;
		end
	end

	// Delay line: take the new byte at the insert point, else shift from the right
	always_ff @(posedge clk) begin
		if (push) begin
			dly_q <= dly_nx;
		end
	end

endmodule

`default_nettype wire

>>> src/mmps_outq.sv
`default_nettype none

module mmps_outq
	import mmps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire bundle_t   bundle,
	output logic           ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);

	bundle_t s0_q, s1_q, s0_nx, s1_nx, rest;
	logic    v0_q, v1_q, v0_nx, v1_nx;
	logic    last, fire, done;
	kind_t   kind;

	assign ready     = !v1_q;
	assign out_valid = v0_q;

	// Pick the first pending result of the head bundle and drop it from the rest
	always_comb begin
		rest = s0_q;
		kind = KIND_END;
		if (s0_q.byte_v) begin
			kind        = KIND_BYTE;
			rest.byte_v = 1'b0;
		end else if (s0_q.comp_v) begin
			kind        = KIND_COMPLETE;
			rest.comp_v = 1'b0;
		end else if (s0_q.ab_v) begin
			kind      = KIND_ABANDON;
			rest.ab_v = 1'b0;
		end else begin
			rest.end_v = 1'b0;
		end
		last = !(rest.byte_v || rest.comp_v || rest.ab_v || rest.end_v);
	end

	assign out_data.kind        = kind;
	assign out_data.part_byte   = s0_q.byte_v ? s0_q.part_byte : 8'h00;
	assign out_data.last_of_run = last;

	assign fire = v0_q && out_ready;
	assign done = fire && last;

	always_comb begin
		s0_nx = s0_q;
		s1_nx = s1_q;
		v0_nx = v0_q;
		v1_nx = v1_q;
		if (done) begin
			if (v1_q) begin
				s0_nx = s1_q;
				v1_nx = 1'b0;
			end else begin
				v0_nx = 1'b0;
			end
		end else if (fire) begin
			s0_nx = rest;
		end
		if (push) begin
			if (!v0_nx) begin
				s0_nx = bundle;
				v0_nx = 1'b1;
			end else begin
				s1_nx = bundle;
				v1_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			v0_q <= v0_nx;
			v1_q <= v1_nx;
		end
	end

	always_ff @(posedge clk) begin
		s0_q <= s0_nx;
		s1_q <= s1_nx;
	end

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !v1_q)
		else $error("bundle pushed into a full queue");

	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		v1_q |-> v0_q)
		else $error("second slot holds a bundle while the head is empty");

endmodule

`default_nettype wire

>>> src/mime_multipart_part_splitter.sv
`default_nettype none

// Multipart body splitter. Load the boundary string first with op = load items
// (one byte per item at char_index), then write boundary_length through cfg_we /
// cfg_data; a write restarts the parse and drops any bytes held. Body bytes then
// stream in one per item, and end_of_body marks the last byte of a body. The block
// finds the first "--boundary", stops on a following "--", otherwise skips to CRLF
// and opens a part. Part bytes come out delayed by boundary_length + 4 bytes so
// the closing CRLF--boundary is never shown; a closed part gives a complete mark,
// a part cut off by the end of the body gives an abandon mark, and every body end
// gives an end mark. One item is accepted per clock while the output queue has
// room; its results are registered and leave one per clock while out_ready is
// high, so the output port sets the rate, and a two-bundle output queue keeps
// input acceptance running while results wait. The window is a row of
// cells, one per delimiter byte, that shift the body bytes toward the oldest end;
// every cell compares its byte against its pattern byte in parallel, so a
// boundary byte loaded mid-body takes effect on the next compare. An unwritten
// boundary byte compares as zero.
module mime_multipart_part_splitter
	import mmps_pkg::*;
#(
	parameter int MAX_BOUNDARY = 70
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_item_t   in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_item_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_data
);

	// Four prefix cells (CR LF - -) ahead of one cell per boundary byte
	localparam int NCELL = MAX_BOUNDARY + 4;
	localparam int LW    = $clog2(NCELL + 1);
	localparam int IW    = $clog2(NCELL);

	typedef enum logic [2:0] {
		PH_PREAMBLE,
		PH_AFTER,
		PH_DASH,
		PH_SKIP,
		PH_SKIP_CR,
		PH_PART,
		PH_DONE
	} phase_t;

	phase_t          phase_q, ph_nx;
	logic [LW-1:0]   cnt_q, cnt_nx, cnt_inc;
	logic [LW-1:0]   len_q, len_nx;
	logic [IW-1:0]   ins_idx;
	logic [LW:0]     len_x, cnt_x;
	logic            pre_ok, part_ok, part_pop;

	logic            acc, body, load, push, is_part, end_hit;
	logic [7:0]      b;
	bundle_t         bnd;
	logic            bnd_push;

	logic [NCELL-1:0] rng, hit, ins_v, ld_v;
	logic [7:0]       dly [NCELL];

	assign acc  = in_valid && in_ready;
	assign body = acc && (in_data.op == OP_BODY);
	assign load = acc && (in_data.op == OP_LOAD);
	assign b    = in_data.data_byte;

	assign is_part = (phase_q == PH_PART);
	// The window shifts only while hunting the opening delimiter or inside a part
	assign push    = body && (is_part || (phase_q == PH_PREAMBLE));

	// Last boundary byte sits in cell len + 3; new bytes enter the delay line there too
	assign ins_idx = IW'({1'b0, len_q} + (LW + 1)'(3));
	// Every cell inside the delimiter agrees with the window after this shift
	assign end_hit = &(hit | ~rng);

	assign len_x    = {1'b0, len_q};
	assign cnt_x    = {1'b0, cnt_q};
	assign pre_ok   = cnt_x >= len_x + (LW + 1)'(1);
	assign part_ok  = cnt_x >= len_x + (LW + 1)'(3);
	assign part_pop = cnt_x >= len_x + (LW + 1)'(4);
	assign cnt_inc  = (cnt_q == LW'(NCELL)) ? cnt_q : cnt_q + LW'(1);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		localparam logic [7:0] INIT = (k == 0) ? CH_CR :
			(k == 1) ? CH_LF : (k < 4) ? CH_DASH : 8'h00;

		assign ins_v[k] = (ins_idx == IW'(k));

		if (k < 2) begin : g_crlf
			// The opening delimiter has no CRLF in front of it
			assign rng[k] = is_part;
		end else if (k < 4) begin : g_dash
			assign rng[k] = 1'b1;
		end else begin : g_win
			assign rng[k] = (IW'(k) <= ins_idx);
		end

		if (k < 4) begin : g_fixed
			assign ld_v[k] = 1'b0;
		end else begin : g_bnd
			assign ld_v[k] = load && (in_data.char_index == 7'(k - 4));
		end

		if (k == NCELL - 1) begin : g_tail
			mmps_cell #(.INIT_BYTE(INIT)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.push     (push),
				.ld       (ld_v[k]),
				.byte_in  (b),
				.ins      (ins_v[k]),
				.dly_in   (8'h00),
				.hit      (hit[k]),
				.dly_out  (dly[k])
			);
		end else begin : g_body
			mmps_cell #(.INIT_BYTE(INIT)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.push     (push),
				.ld       (ld_v[k]),
				.byte_in  (b),
				.ins      (ins_v[k]),
				.dly_in   (dly[k+1]),
				.hit      (hit[k]),
				.dly_out  (dly[k])
			);
		end
	end

	// Clamp the written length into 1..MAX_BOUNDARY
	always_comb begin
		if (cfg_data == 7'd0) begin
			len_nx = LW'(1);
		end else if ({1'b0, cfg_data} > 8'(MAX_BOUNDARY)) begin
			len_nx = LW'(MAX_BOUNDARY);
		end else begin
			len_nx = LW'(cfg_data);
		end
	end

	// Next phase, window count and the results of this body byte
	always_comb begin
		ph_nx  = phase_q;
		cnt_nx = cnt_q;
		bnd    = '0;
		if (body) begin
			case (phase_q)
				PH_PREAMBLE: begin
					if (pre_ok && end_hit) begin
						cnt_nx = '0;
						ph_nx  = PH_AFTER;
					end else begin
						cnt_nx = cnt_inc;
					end
				end
				PH_AFTER, PH_DASH: begin
					if (b == CH_DASH && phase_q == PH_DASH) begin
						ph_nx = PH_DONE;
					end else if (b == CH_DASH) begin
						ph_nx = PH_DASH;
					end else if (b == CH_CR) begin
						ph_nx = PH_SKIP_CR;
					end else begin
						ph_nx = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (b == CH_CR) begin
						ph_nx = PH_SKIP_CR;
					end
				end
				PH_SKIP_CR: begin
					if (b == CH_LF) begin
						cnt_nx = '0;
						ph_nx  = PH_PART;
					end else if (b != CH_CR) begin
						ph_nx = PH_SKIP;
					end
				end
				PH_PART: begin
					// Release the oldest byte once the window is full
					if (part_pop) begin
						bnd.byte_v    = 1'b1;
						bnd.part_byte = dly[0];
					end
					if (part_ok && end_hit) begin
						bnd.comp_v = 1'b1;
						cnt_nx     = '0;
						ph_nx      = PH_AFTER;
					end else begin
						cnt_nx = cnt_inc;
					end
				end
				default: begin
					ph_nx = PH_DONE;
				end
			endcase
			if (in_data.end_of_body) begin
				bnd.ab_v  = (ph_nx == PH_PART);
				bnd.end_v = 1'b1;
				ph_nx     = PH_PREAMBLE;
				cnt_nx    = '0;
			end
		end
	end

	assign bnd_push = bnd.byte_v || bnd.comp_v || bnd.ab_v || bnd.end_v;

	// A length write restarts the parse and wins over this cycle's phase and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREAMBLE;
			cnt_q   <= '0;
			len_q   <= LW'(1);
		end else if (cfg_we) begin
			len_q   <= len_nx;
			phase_q <= PH_PREAMBLE;
			cnt_q   <= '0;
		end else begin
			phase_q <= ph_nx;
			cnt_q   <= cnt_nx;
		end
	end

	mmps_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (bnd_push),
		.bundle   (bnd),
		.ready    (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (phase_q == PH_PREAMBLE && cnt_q == '0))
		else $error("length write did not restart the parse");

	a_byte_in_part: assert property (@(posedge clk) disable iff (!arst_n)
		(bnd_push && bnd.byte_v) |-> (phase_q == PH_PART))
		else $error("part byte released outside a part");

	a_abandon_ends: assert property (@(posedge clk) disable iff (!arst_n)
		bnd.ab_v |-> (bnd.end_v && !bnd.comp_v))
		else $error("abandon mark without body end or with a complete mark");

endmodule

`default_nettype wire

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mmps_pkg::*;

	localparam int unsigned BOUNDARY_MAX  = 70;
	localparam int unsigned WINDOW_CAP    = BOUNDARY_MAX + 4;
	localparam int unsigned CLK_HALF      = 10;
	localparam int unsigned RESET_CYCLES  = 11;
	// Extra wait once the owed results have come; give stragglers room.
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned CYCLE_LIMIT   = 200000;

	// Register settings per phase, lowest field first: 0 is the clamped low end.
	localparam int unsigned PHASE_COUNT = 3;
	localparam logic [7*PHASE_COUNT-1:0] PHASE_LENGTHS = {7'd2, 7'd4, 7'd0};
	localparam int unsigned HOLD_PHASE  = 1;

	// Opening body with a one-byte boundary of 8'hFF: preamble match, CR CR LF before
	// the part, one part byte released by the delimiter, closing dashes, trailing byte.
	localparam logic [8*15-1:0] OPENING_BODY = {CH_DASH, CH_DASH, 8'hFF, CH_CR, CH_CR, CH_LF,
		8'h00, CH_CR, CH_LF, CH_DASH, CH_DASH, 8'hFF, CH_DASH, CH_DASH, 8'h55};
	// Second body: padding after the boundary, then the body ends inside the part.
	localparam logic [8*7-1:0] CUT_BODY = {CH_DASH, CH_DASH, 8'hFF, 8'h61, CH_CR, CH_LF, 8'h7F};

	typedef enum logic [2:0] {
		SCAN_PREAMBLE,
		SCAN_AFTER,
		SCAN_DASH,
		SCAN_SKIP,
		SCAN_SKIP_CR,
		SCAN_PART,
		SCAN_DONE
	} scan_t;

	typedef enum logic [1:0] {
		BODY_CLOSED,
		BODY_ENDS_ON_DELIM,
		BODY_CUT,
		BODY_NOISE
	} body_style_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_COMB
	} stall_mode_t;

	// Tracks the splitter state transaction by transaction and holds the results
	// still owed by the block, oldest first.
	class splitter_scoreboard;
		logic [7:0]  boundary_bytes [BOUNDARY_MAX];
		logic [7:0]  window_bytes [WINDOW_CAP];
		int unsigned window_count;
		scan_t       scan;
		logic [6:0]  length_reg;
		out_item_t   step_results [$];
		out_item_t   due_results [$];
		int unsigned failures;

		function new();
			foreach (boundary_bytes[i]) boundary_bytes[i] = 8'h00;
			length_reg = 7'd1;
			failures = 0;
			restart();
		endfunction

		// Empty the window and go back to looking for the first boundary.
		function void restart();
			foreach (window_bytes[i]) window_bytes[i] = 8'h00;
			window_count = 0;
			scan = SCAN_PREAMBLE;
		endfunction

		function void set_length(input logic [6:0] value);
			length_reg = value;
			restart();
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// Shift a byte into a window w bytes wide; hand back the byte pushed out.
		function bit shift_in(input logic [7:0] b, input int unsigned w, output logic [7:0] gone);
			bit          left;
			int unsigned i;
			left = 1'b0;
			gone = 8'h00;
			if (window_count >= w && window_count > 0) begin
				gone = window_bytes[0];
				for (i = 1; i < window_count; i++) window_bytes[i-1] = window_bytes[i];
				window_count--;
				left = 1'b1;
			end
			if (window_count < WINDOW_CAP) begin
				window_bytes[window_count] = b;
				window_count++;
			end
			return left;
		endfunction

		// True when the window holds exactly the prefix followed by the boundary.
		function bit holds(input logic [31:0] prefix, input int unsigned plen,
			input int unsigned l);
			int unsigned i;
			if (window_count != plen + l) return 1'b0;
			for (i = 0; i < plen; i++)
				if (window_bytes[i] != prefix[31 - 8*i -: 8]) return 1'b0;
			for (i = 0; i < l; i++)
				if (window_bytes[plen + i] != boundary_bytes[i]) return 1'b0;
			return 1'b1;
		endfunction

		function void add_result(input kind_t k, input logic [7:0] b);
			out_item_t r;
			r.kind = k;
			r.part_byte = b;
			r.last_of_run = 1'b0;
			step_results.push_back(r);
		endfunction

		// Advance the parse by one accepted input transaction and queue its results.
		function void accept_item(input in_item_t it);
			int unsigned l;
			logic [7:0]  b;
			logic [7:0]  gone;
			out_item_t   r;
			b = it.data_byte;
			if (it.op == OP_LOAD) begin
				if (it.char_index < BOUNDARY_MAX) boundary_bytes[it.char_index] = b;
				return;
			end
			l = (length_reg == 0) ? 1 : (length_reg > BOUNDARY_MAX) ? BOUNDARY_MAX : length_reg;
			step_results.delete();
			case (scan)
				SCAN_PREAMBLE: begin
					void'(shift_in(b, l + 2, gone));
					if (holds({CH_DASH, CH_DASH, 16'h0000}, 2, l)) begin
						window_count = 0;
						scan = SCAN_AFTER;
					end
				end
				SCAN_AFTER, SCAN_DASH: begin
					if (b == CH_DASH) scan = (scan == SCAN_DASH) ? SCAN_DONE : SCAN_DASH;
					else if (b == CH_CR) scan = SCAN_SKIP_CR;
					else scan = SCAN_SKIP;
				end
				SCAN_SKIP: begin
					if (b == CH_CR) scan = SCAN_SKIP_CR;
				end
				SCAN_SKIP_CR: begin
					if (b == CH_LF) begin
						window_count = 0;
						scan = SCAN_PART;
					end else if (b != CH_CR) begin
						scan = SCAN_SKIP;
					end
				end
				SCAN_PART: begin
					if (shift_in(b, l + 4, gone)) add_result(KIND_BYTE, gone);
					if (holds({CH_CR, CH_LF, CH_DASH, CH_DASH}, 4, l)) begin
						add_result(KIND_COMPLETE, 8'h00);
						window_count = 0;
						scan = SCAN_AFTER;
					end
				end
				default: scan = SCAN_DONE;
			endcase
			if (it.end_of_body) begin
				if (scan == SCAN_PART) add_result(KIND_ABANDON, 8'h00);
				add_result(KIND_END, 8'h00);
				restart();
			end
			if (step_results.size() != 0) begin
				r = step_results.pop_back();
				r.last_of_run = 1'b1;
				step_results.push_back(r);
			end
			foreach (step_results[i]) due_results.push_back(step_results[i]);
		endfunction

		// Compare one output transaction against the oldest result owed.
		function void check_result(input out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				$error("result with nothing due: kind %0d, part_byte 0x%02h, last_of_run %0b",
					got.kind, got.part_byte, got.last_of_run);
				failures++;
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				failures++;
			end
			if (got.part_byte !== want.part_byte) begin
				$error("part_byte: expected 0x%02h, actual 0x%02h", want.part_byte, got.part_byte);
				failures++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
				failures++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_item_t  out_data;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_data = 7'd0;

	splitter_scoreboard sb;
	in_item_t           stim_q [$];
	logic [7:0]         bnd_copy [BOUNDARY_MAX];
	int unsigned        burst_left = 0;
	bit                 hold_req = 1'b0;
	int unsigned        cycle_count = 0;

	mime_multipart_part_splitter #(
		.MAX_BOUNDARY(BOUNDARY_MAX)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: a hung handshake or a missing result ends here.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("mime_multipart_part_splitter test failed");
		$finish;
	end

	// Sample both channels at the rising edge. Note the input first: a result never
	// comes from the transaction accepted at the same edge, so order is safe.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.accept_item(in_data);
			if (out_valid && out_ready) sb.check_result(out_data);
		end
	end

	// Receiver: switch between stall patterns in stretches of random length, and
	// honor a requested long hold-off, counted here, while the sender keeps going.
	initial begin : receiver
		int unsigned hold_left;
		int unsigned stretch;
		int unsigned tick;
		stall_mode_t mode;
		logic        ready_next;
		hold_left = 0;
		stretch = 0;
		tick = 0;
		mode = RX_OPEN;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				ready_next = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					stretch = $urandom_range(4, 64);
				end
				stretch--;
				tick++;
				case (mode)
					RX_OPEN:  ready_next = 1'b1;
					RX_LIGHT: ready_next = ($urandom_range(0, 3) != 0);
					RX_HEAVY: ready_next = ($urandom_range(0, 2) == 0);
					default:  ready_next = ((tick % 5) < 2);
				endcase
			end
			out_ready <= ready_next;
		end
	end

	// Mostly printable, now and then any byte value.
	function automatic logic [7:0] boundary_char();
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(8'h30, 8'h7A));
	endfunction

	// Lean toward the delimiter characters so near matches show up often.
	function automatic logic [7:0] body_char();
		case ($urandom_range(0, 9))
			0:       return CH_CR;
			1:       return CH_LF;
			2:       return CH_DASH;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void queue_byte(input logic [7:0] b, input logic eob);
		in_item_t it;
		it.op = OP_BODY;
		it.char_index = 7'($urandom_range(0, 127));
		it.data_byte = b;
		it.end_of_body = eob;
		stim_q.push_back(it);
	endfunction

	function automatic void queue_load(input logic [6:0] idx, input logic [7:0] b,
		input logic eob);
		in_item_t it;
		it.op = OP_LOAD;
		it.char_index = idx;
		it.data_byte = b;
		it.end_of_body = eob;
		stim_q.push_back(it);
	endfunction

	// Queue one body for boundary length l. Well-formed bodies open with up to four
	// random bytes and the boundary, carry one or two parts and end as the style says;
	// noise bodies are random bytes mixed with boundary rewrites.
	function automatic void queue_body(input int unsigned l, input body_style_t style,
		input int unsigned cmax);
		logic [7:0]  text [$];
		logic [7:0]  b;
		int unsigned parts;
		int unsigned n;
		int unsigned p;
		int unsigned i;
		int unsigned j;
		int unsigned k;
		if (style == BODY_NOISE) begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					k = $urandom_range(0, 127);
					b = 8'($urandom_range(0, 255));
					if (k < BOUNDARY_MAX) bnd_copy[k] = b;
					queue_load(7'(k), b, 1'($urandom_range(0, 1)));
				end
				queue_byte(body_char(), (i == n - 1) && ($urandom_range(0, 3) != 0));
			end
			return;
		end
		n = $urandom_range(0, 4);
		repeat (n) text.push_back(body_char());
		text.push_back(CH_DASH);
		text.push_back(CH_DASH);
		for (i = 0; i < l; i++) text.push_back(bnd_copy[i]);
		parts = (l > 20) ? 1 : $urandom_range(1, 2);
		for (p = 0; p < parts; p++) begin
			// Transport padding after the boundary, then CRLF opens the part.
			n = $urandom_range(0, 2);
			repeat (n) text.push_back(8'($urandom_range(8'h41, 8'h5A)));
			if ($urandom_range(0, 4) == 0) text.push_back(CH_CR);
			text.push_back(CH_CR);
			text.push_back(CH_LF);
			n = $urandom_range(0, cmax);
			for (i = 0; i < n; i++) begin
				// Now and then plant a delimiter that stops short of the full boundary.
				if ($urandom_range(0, 15) == 0) begin
					text.push_back(CH_CR);
					text.push_back(CH_LF);
					text.push_back(CH_DASH);
					text.push_back(CH_DASH);
					k = $urandom_range(0, l - 1);
					for (j = 0; j < k; j++) text.push_back(bnd_copy[j]);
				end
				text.push_back(body_char());
			end
			if (style == BODY_CUT && p == parts - 1) break;
			text.push_back(CH_CR);
			text.push_back(CH_LF);
			text.push_back(CH_DASH);
			text.push_back(CH_DASH);
			for (i = 0; i < l; i++) text.push_back(bnd_copy[i]);
		end
		if (style == BODY_CLOSED) begin
			text.push_back(CH_DASH);
			text.push_back(CH_DASH);
			n = $urandom_range(0, 3);
			repeat (n) text.push_back(body_char());
		end
		// Drop in a rare load that leaves the active boundary as it is.
		for (i = 0; i < text.size(); i++) begin
			if ($urandom_range(0, 39) == 0) begin
				k = $urandom_range(0, 127);
				b = (k < l) ? bnd_copy[k] : 8'($urandom_range(0, 255));
				if (k < BOUNDARY_MAX) bnd_copy[k] = b;
				queue_load(7'(k), b, 1'($urandom_range(0, 1)));
			end
			queue_byte(text[i], i == text.size() - 1);
		end
	endfunction

	// Offer one input transaction; hold valid and payload until it is accepted.
	// Bursts of random length alternate with gaps of random length.
	task automatic send_item(input in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid, wait until every owed result has come, then let the block settle.
	task automatic drain_and_settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_queued();
		while (stim_q.size() != 0) begin
			if ($urandom_range(0, 99) == 0) drain_and_settle();
			send_item(stim_q.pop_front());
		end
	endtask

	initial begin : stimulus
		int unsigned ph;
		int unsigned l;
		int unsigned r;
		int unsigned i;
		logic [6:0]  len;
		body_style_t style;
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset length of one, boundary byte 8'hFF; an out-of-range index
		// load is ignored and an end mark on a load does nothing.
		queue_load(7'd0, 8'hFF, 1'b1);
		queue_load(7'd127, 8'h00, 1'b0);
		for (i = 0; i < 15; i++) queue_byte(OPENING_BODY[8*(14 - i) +: 8], i == 14);
		for (i = 0; i < 7; i++) queue_byte(CUT_BODY[8*(6 - i) +: 8], i == 6);
		send_queued();

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			len = PHASE_LENGTHS[7*ph +: 7];
			l = (len == 0) ? 1 : (len > BOUNDARY_MAX) ? BOUNDARY_MAX : len;
			// Load a fresh boundary; loads leave the parse alone.
			for (i = 0; i < l; i++) begin
				bnd_copy[i] = boundary_char();
				queue_load(7'(i), bnd_copy[i], 1'($urandom_range(0, 1)));
			end
			send_queued();
			// Wait for every owed result, so the length is written with the block idle.
			drain_and_settle();
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_data <= len;
			@(posedge clk);
			sb.set_length(len);
			@(negedge clk);
			cfg_we <= 1'b0;

			r = $urandom_range(0, 19);
			style = (r < 11) ? BODY_CLOSED : (r < 14) ? BODY_ENDS_ON_DELIM :
				(r < 17) ? BODY_CUT : BODY_NOISE;
			if (ph == HOLD_PHASE) begin
				// Long part while the receiver holds off: the block must fill up
				// and stall its input.
				queue_body(l, BODY_CLOSED, 16);
				hold_req = 1'b1;
			end else begin
				queue_body(l, style, 6);
			end
			send_queued();
		end

		drain_and_settle();
		if (sb.failures == 0) begin
			$display("mime_multipart_part_splitter test passed");
		end else begin
			$display("mime_multipart_part_splitter test failed");
		end
		$finish;
	end
endmodule
